// ----- hw/rtl/lfupbm_pkg.sv -----
package lfupbm_pkg;

    localparam int NUM_FRAMES_DEF   = 16;
    localparam int FILE_ID_BITS_DEF = 8;

    localparam int OP_W    = 2;
    localparam int FILE_W  = 8;
    localparam int PAGE_W  = 32;
    localparam int KIND_W  = 2;
    localparam int FIDX_W  = 4;
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT       = 2'd0,
        KIND_INSTALL   = 2'd1,
        KIND_WRITEBACK = 2'd2,
        KIND_DONE      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_INSTALL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic writeback;
        logic install;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic is_close;
        logic scan_last;
        logic hit;
        logic victim_dirty;
    } status_t;

endpackage

// ----- hw/rtl/lfupbm_ctrl.sv -----
module lfupbm_ctrl
    import lfupbm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] operation,
    input  status_t         status,
    output cmd_t            cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (operation != OP_NOP))
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (!status.is_close && status.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.scan_last)
                begin
                    state_next = status.is_close ? ST_DONE : ST_EVICT;
                end
            end
            ST_EVICT:
            begin
                if (status.victim_dirty)
                begin
                    cmd.writeback = 1'b1;
                    state_next    = ST_INSTALL;
                end
                else
                begin
                    cmd.install = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_INSTALL:
            begin
                cmd.install = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DONE:
            begin
                cmd.done   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/lfupbm_datapath.sv -----
module lfupbm_datapath
    import lfupbm_pkg::*;
#(
    parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
    parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               active_frames_we,
    input  logic [CFG_W-1:0]   active_frames_wdata,
    input  logic [OP_W-1:0]    operation,
    input  logic [FILE_W-1:0]  file_id,
    input  logic [PAGE_W-1:0]  page_num,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               result_valid,
    output logic [KIND_W-1:0]  result_kind,
    output logic [FIDX_W-1:0]  frame_index,
    output logic [FILE_W-1:0]  out_file_id,
    output logic [PAGE_W-1:0]  out_page_num,
    output logic               last
);

    localparam int IDXW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [CFG_W-1:0]        active_reg;

    logic                    valid_reg [NUM_FRAMES];
    logic [FILE_ID_BITS-1:0] file_reg  [NUM_FRAMES];
    logic [PAGE_W-1:0]       page_reg  [NUM_FRAMES];
    logic                    dirty_reg [NUM_FRAMES];
    logic [COUNT_W-1:0]      count_reg [NUM_FRAMES];

    logic                    is_close_reg;
    logic                    is_write_reg;
    logic [FILE_ID_BITS-1:0] req_file_reg;
    logic [PAGE_W-1:0]       req_page_reg;
    logic [IDXW-1:0]         last_idx_reg;
    logic [IDXW-1:0]         idx_reg;

    logic [IDXW-1:0]         victim_reg;
    logic [COUNT_W-1:0]      best_reg;
    logic                    vvalid_reg;
    logic                    vdirty_reg;
    logic [FILE_ID_BITS-1:0] vfile_reg;
    logic [PAGE_W-1:0]       vpage_reg;

    logic                    res_valid_reg;
    kind_t                   res_kind_reg;
    logic [FIDX_W-1:0]       res_idx_reg;
    logic [FILE_W-1:0]       res_file_reg;
    logic [PAGE_W-1:0]       res_page_reg;
    logic                    res_last_reg;

    logic [IDXW-1:0]         last_idx_next;
    logic                    cur_valid;
    logic [FILE_ID_BITS-1:0] cur_file;
    logic [PAGE_W-1:0]       cur_page;
    logic                    cur_dirty;
    logic [COUNT_W-1:0]      cur_count;
    logic                    file_match;
    logic                    hit;
    logic                    close_wb;
    logic                    take_victim;

    logic                    emit;
    kind_t                   e_kind;
    logic [IDXW-1:0]         e_idx;
    logic [FILE_ID_BITS-1:0] e_file;
    logic [PAGE_W-1:0]       e_page;
    logic                    e_last;

    // clamp active count to 1..NUM_FRAMES
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_idx_next = '0;
        end
        else if (int'(active_reg) > NUM_FRAMES)
        begin
            last_idx_next = IDXW'(NUM_FRAMES - 1);
        end
        else
        begin
            last_idx_next = IDXW'(active_reg - CFG_W'(1));
        end
    end

    assign cur_valid  = valid_reg[idx_reg];
    assign cur_file   = file_reg[idx_reg];
    assign cur_page   = page_reg[idx_reg];
    assign cur_dirty  = dirty_reg[idx_reg];
    assign cur_count  = count_reg[idx_reg];
    assign file_match = cur_valid && (cur_file == req_file_reg);
    assign hit        = file_match && (cur_page == req_page_reg);
    assign close_wb   = cmd.scan && is_close_reg && file_match && cur_dirty;
    assign take_victim = cmd.scan && !is_close_reg &&
                         ((idx_reg == '0) || (cur_count < best_reg));

    assign status.is_close     = is_close_reg;
    assign status.scan_last    = (idx_reg == last_idx_reg);
    assign status.hit          = hit;
    assign status.victim_dirty = vvalid_reg && vdirty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (active_frames_we)
        begin
            active_reg <= active_frames_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                file_reg[i]  <= '0;
                page_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
                count_reg[i] <= '0;
            end
        end
        else if (cmd.scan && is_close_reg && file_match)
        begin
            valid_reg[idx_reg] <= 1'b0;
            file_reg[idx_reg]  <= '0;
            page_reg[idx_reg]  <= '0;
            dirty_reg[idx_reg] <= 1'b0;
        end
        else if (cmd.scan && !is_close_reg && hit)
        begin
            if (cur_count != COUNT_MAX)
            begin
                count_reg[idx_reg] <= cur_count + COUNT_W'(1);
            end
            if (is_write_reg)
            begin
                dirty_reg[idx_reg] <= 1'b1;
            end
        end
        else if (cmd.install)
        begin
            valid_reg[victim_reg] <= 1'b1;
            file_reg[victim_reg]  <= req_file_reg;
            page_reg[victim_reg]  <= req_page_reg;
            dirty_reg[victim_reg] <= is_write_reg;
            count_reg[victim_reg] <= COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_close_reg <= (operation == OP_CLOSE);
            is_write_reg <= (operation == OP_WRITE);
            req_file_reg <= FILE_ID_BITS'(file_id);
            req_page_reg <= page_num;
            last_idx_reg <= last_idx_next;
            idx_reg      <= '0;
        end
        else if (cmd.scan && (idx_reg != last_idx_reg))
        begin
            idx_reg <= idx_reg + IDXW'(1);
        end
        if (take_victim)
        begin
            victim_reg <= idx_reg;
            best_reg   <= cur_count;
            vvalid_reg <= cur_valid;
            vdirty_reg <= cur_dirty;
            vfile_reg  <= cur_file;
            vpage_reg  <= cur_page;
        end
    end

    always_comb
    begin
        emit   = 1'b0;
        e_kind = KIND_HIT;
        e_idx  = idx_reg;
        e_file = req_file_reg;
        e_page = req_page_reg;
        e_last = 1'b1;
        if (close_wb)
        begin
            emit   = 1'b1;
            e_kind = KIND_WRITEBACK;
            e_file = cur_file;
            e_page = cur_page;
            e_last = 1'b0;
        end
        else if (cmd.scan && !is_close_reg && hit)
        begin
            emit = 1'b1;
        end
        else if (cmd.writeback)
        begin
            emit   = 1'b1;
            e_kind = KIND_WRITEBACK;
            e_idx  = victim_reg;
            e_file = vfile_reg;
            e_page = vpage_reg;
            e_last = 1'b0;
        end
        else if (cmd.install)
        begin
            emit   = 1'b1;
            e_kind = KIND_INSTALL;
            e_idx  = victim_reg;
        end
        else if (cmd.done)
        begin
            emit   = 1'b1;
            e_kind = KIND_DONE;
            e_idx  = '0;
            e_page = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_kind_reg <= e_kind;
            res_idx_reg  <= FIDX_W'(e_idx);
            res_file_reg <= FILE_W'(e_file);
            res_page_reg <= e_page;
            res_last_reg <= e_last;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign frame_index  = res_idx_reg;
    assign out_file_id  = res_file_reg;
    assign out_page_num = res_page_reg;
    assign last         = res_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.writeback, cmd.install, cmd.done}))
        else $error("more than one datapath command");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.writeback |-> (vvalid_reg && vdirty_reg))
        else $error("writeback of a clean or empty victim");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.install |=> (res_valid_reg && (res_kind_reg == KIND_INSTALL) && res_last_reg))
        else $error("install did not yield a final install result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.install |=> valid_reg[$past(victim_reg)])
        else $error("installed frame not valid");
`endif

endmodule

// ----- hw/rtl/lfu_page_buffer_manager_unit.sv -----
// LFU page buffer manager: tags and replacement policy for a pool of frames.
// Request channel: drive operation, file_id, page_num and pulse start; the
// request transfers on a rising edge with start high and busy low. Operation
// code 3 is taken and dropped without any result.
// Result channel: each result is valid for one cycle with result_valid high;
// last marks the final result of a request. The receiver cannot stall.
// Config: active_frames_we / active_frames_wdata write the active frame
// count; write only while busy is low and no result is pending.
// Sequence, n = clamped active frame count, one frame examined per cycle:
//   hit on frame i: the scan stops at frame i and the hit result is registered.
//   miss: all n frames are scanned, then writeback if the victim is dirty, then install.
//   close: all n frames are scanned; writebacks stream during the scan, then done.
// A new request may transfer the cycle busy falls, while the last result
// is still on the output register.
// Reset clears all frames, counts and dirty bits and sets the active
// frame count to 16; no clearing sweep is needed.
module lfu_page_buffer_manager_unit
    import lfupbm_pkg::*;
#(
    parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
    parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active_frames_we,
    input  logic [CFG_W-1:0]  active_frames_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   operation,
    input  logic [FILE_W-1:0] file_id,
    input  logic [PAGE_W-1:0] page_num,
    output logic              result_valid,
    output logic [KIND_W-1:0] result_kind,
    output logic [FIDX_W-1:0] frame_index,
    output logic [FILE_W-1:0] out_file_id,
    output logic [PAGE_W-1:0] out_page_num,
    output logic              last
);

    cmd_t    cmd;
    status_t status;

    lfupbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    lfupbm_datapath #(
        .NUM_FRAMES   (NUM_FRAMES),
        .FILE_ID_BITS (FILE_ID_BITS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .active_frames_we    (active_frames_we),
        .active_frames_wdata (active_frames_wdata),
        .operation           (operation),
        .file_id             (file_id),
        .page_num            (page_num),
        .cmd                 (cmd),
        .status              (status),
        .result_valid        (result_valid),
        .result_kind         (result_kind),
        .frame_index         (frame_index),
        .out_file_id         (out_file_id),
        .out_page_num        (out_page_num),
        .last                (last)
    );

endmodule
